// ===== sv/srpq_pkg.sv =====
`default_nettype none
package srpq_pkg;

    localparam int DEPTH  = 16;
    localparam int PAY_W  = 32;
    localparam int PRI_W  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PLACE,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [PRI_W-1:0] pri;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    // Out-of-range capacity values clamp: zero acts as one, above DEPTH acts as DEPTH.
    function automatic logic [CNT_W-1:0] cap_eff(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] res;
        if (raw == '0) begin
            res = CNT_W'(1);
        end else if (raw > CNT_W'(DEPTH)) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = raw;
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] last;
        last = cap - CNT_W'(1);
        return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] last;
        last = cap - CNT_W'(1);
        return (idx == last[IDX_W-1:0]) ? '0 : idx + IDX_W'(1);
    endfunction

endpackage
`default_nettype wire

// ===== sv/srpq_ram.sv =====
`default_nettype none
module srpq_ram (
    input  wire logic              i_clk,
    input  wire srpq_pkg::t_ram_req i_req,
    output srpq_pkg::t_entry       o_rdata
);

    srpq_pkg::t_entry r_mem [srpq_pkg::DEPTH];
    srpq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/srpq_ctrl.sv =====
`default_nettype none
module srpq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [srpq_pkg::CNT_W-1:0]    i_cap,
    input  wire logic                          i_flush,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_mode,
    input  wire logic [srpq_pkg::PAY_W-1:0]    i_payload,
    input  wire logic signed [srpq_pkg::PRI_W-1:0] i_priority_req,
    output srpq_pkg::t_ram_req                 o_ram_req,
    input  wire srpq_pkg::t_entry              i_ram_rdata,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [srpq_pkg::PAY_W-1:0]         o_payload_out,
    output logic signed [srpq_pkg::PRI_W-1:0]  o_priority_out,
    output logic [1:0]                         o_status,
    output logic [srpq_pkg::CNT_W-1:0]         o_count,
    output logic                               o_empty_res,
    output logic                               o_full_res
);

    srpq_pkg::t_state r_state, n_state;

    logic [srpq_pkg::PAY_W-1:0] r_pay, n_pay;
    logic [srpq_pkg::PRI_W-1:0] r_pri, n_pri;
    logic [srpq_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [srpq_pkg::CNT_W-1:0] r_k, n_k;
    logic [srpq_pkg::IDX_W-1:0] r_rd, n_rd;
    logic [srpq_pkg::IDX_W-1:0] r_wr, n_wr;
    logic [srpq_pkg::CNT_W-1:0] r_fill, n_fill;

    logic [srpq_pkg::PAY_W-1:0] r_res_pay, n_res_pay;
    logic [srpq_pkg::PRI_W-1:0] r_res_pri, n_res_pri;
    logic [1:0]                 r_res_status, n_res_status;

    logic                       r_out_valid, n_out_valid;
    logic [srpq_pkg::PAY_W-1:0] r_out_pay, n_out_pay;
    logic [srpq_pkg::PRI_W-1:0] r_out_pri, n_out_pri;
    logic [1:0]                 r_out_status, n_out_status;
    logic [srpq_pkg::CNT_W-1:0] r_out_count, n_out_count;
    logic                       r_out_empty, n_out_empty;
    logic                       r_out_full, n_out_full;

    logic [srpq_pkg::IDX_W-1:0] pv;
    logic [srpq_pkg::CNT_W-1:0] k_inc;
    srpq_pkg::t_entry           new_entry;
    srpq_pkg::t_ram_req         ram_req;

    assign pv        = srpq_pkg::slot_prev(r_idx, i_cap);
    assign k_inc     = r_k + srpq_pkg::CNT_W'(1);
    assign new_entry = '{payload: r_pay, pri: r_pri};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srpq_pkg::S_IDLE;
            r_rd        <= '0;
            r_wr        <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay        <= n_pay;
        r_pri        <= n_pri;
        r_idx        <= n_idx;
        r_res_pay    <= n_res_pay;
        r_res_pri    <= n_res_pri;
        r_res_status <= n_res_status;
        r_out_pay    <= n_out_pay;
        r_out_pri    <= n_out_pri;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
        r_out_full   <= n_out_full;
    end

    always_comb begin
        n_state      = r_state;
        n_pay        = r_pay;
        n_pri        = r_pri;
        n_idx        = r_idx;
        n_k          = r_k;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_fill       = r_fill;
        n_res_pay    = r_res_pay;
        n_res_pri    = r_res_pri;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_pay    = r_out_pay;
        n_out_pri    = r_out_pri;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        n_out_full   = r_out_full;

        ram_req.we    = 1'b0;
        ram_req.waddr = r_idx;
        ram_req.wdata = new_entry;
        ram_req.raddr = pv;

        case (r_state)
            srpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_pay        = i_payload;
                    n_pri        = i_priority_req;
                    n_res_pay    = '0;
                    n_res_pri    = '0;
                    n_res_status = srpq_pkg::STATUS_DONE;
                    if (i_mode == srpq_pkg::MODE_INSERT) begin
                        if (r_fill >= i_cap) begin
                            n_res_status = srpq_pkg::STATUS_FULL;
                            n_state      = srpq_pkg::S_DONE;
                        end else if (r_fill == '0) begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = r_wr;
                            ram_req.wdata = '{payload: i_payload, pri: i_priority_req};
                            n_wr          = srpq_pkg::slot_next(r_wr, i_cap);
                            n_fill        = r_fill + srpq_pkg::CNT_W'(1);
                            n_state       = srpq_pkg::S_DONE;
                        end else begin
                            ram_req.raddr = srpq_pkg::slot_prev(r_wr, i_cap);
                            n_idx         = r_wr;
                            n_k           = '0;
                            n_state       = srpq_pkg::S_WALK;
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_res_status = srpq_pkg::STATUS_EMPTY;
                            n_state      = srpq_pkg::S_DONE;
                        end else begin
                            ram_req.raddr = r_rd;
                            n_state       = srpq_pkg::S_POP;
                        end
                    end
                end
            end
            srpq_pkg::S_WALK: begin
                // The entry one slot behind the hole is on the read port this cycle.
                ram_req.we = 1'b1;
                if ($signed(i_ram_rdata.pri) > $signed(r_pri)) begin
                    ram_req.wdata = i_ram_rdata;
                    n_idx         = pv;
                    n_k           = k_inc;
                    if (k_inc < r_fill) begin
                        ram_req.raddr = srpq_pkg::slot_prev(pv, i_cap);
                    end else begin
                        n_state = srpq_pkg::S_PLACE;
                    end
                end else begin
                    n_wr    = srpq_pkg::slot_next(r_wr, i_cap);
                    n_fill  = r_fill + srpq_pkg::CNT_W'(1);
                    n_state = srpq_pkg::S_DONE;
                end
            end
            srpq_pkg::S_PLACE: begin
                ram_req.we = 1'b1;
                n_wr       = srpq_pkg::slot_next(r_wr, i_cap);
                n_fill     = r_fill + srpq_pkg::CNT_W'(1);
                n_state    = srpq_pkg::S_DONE;
            end
            srpq_pkg::S_POP: begin
                n_res_pay = i_ram_rdata.payload;
                n_res_pri = i_ram_rdata.pri;
                n_rd      = srpq_pkg::slot_next(r_rd, i_cap);
                n_fill    = r_fill - srpq_pkg::CNT_W'(1);
                n_state   = srpq_pkg::S_DONE;
            end
            srpq_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_pay    = r_res_pay;
                    n_out_pri    = r_res_pri;
                    n_out_status = r_res_status;
                    n_out_count  = r_fill;
                    n_out_empty  = (r_fill == '0);
                    n_out_full   = (r_fill == i_cap);
                    n_state      = srpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srpq_pkg::S_IDLE;
            end
        endcase

        // A capacity write empties the ring; user must keep it to idle; not enforced.
        if (i_flush) begin
            n_rd   = '0;
            n_wr   = '0;
            n_fill = '0;
        end
    end

    assign o_ram_req      = ram_req;
    assign o_in_ready     = (r_state == srpq_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_payload_out  = r_out_pay;
    assign o_priority_out = r_out_pri;
    assign o_status       = r_out_status;
    assign o_count        = r_out_count;
    assign o_empty_res    = r_out_empty;
    assign o_full_res     = r_out_full;

    a_walk_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpq_pkg::S_WALK && n_state == srpq_pkg::S_WALK)
            |-> (ram_req.raddr != ram_req.waddr))
        else $error("walk reads the slot it is writing");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_cap)
        else $error("fill count exceeds capacity");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpq_pkg::S_WALK) |-> (r_k < r_fill))
        else $error("walk ran past the read slot");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpq_pkg::S_IDLE && i_in_valid) |=> (r_state != srpq_pkg::S_IDLE))
        else $error("accepted word was not started");

endmodule
`default_nettype wire

// ===== sv/sorted_ring_priority_queue_core.sv =====
// On acceptance, a rejected word or an insert into an empty ring goes straight to S_DONE,
// a remove reads the head through S_POP, and any other insert that shifts s entries walks
// S_WALK (then S_PLACE if s equals the fill) before S_DONE loads the output register. The
// next word is accepted in the cycle after that load, one item at a time. A worst-case
// insert shifts 15 entries, one per cycle, bound by the single RAM read and write port.
// Synchronous active-low reset empties the ring and sets capacity to 16; RAM is not cleared.
`default_nettype none
module sorted_ring_priority_queue_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [srpq_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [srpq_pkg::DATA_W-1:0]       pwdata,
    output logic [srpq_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_mode,
    input  wire logic [srpq_pkg::PAY_W-1:0]        i_payload,
    input  wire logic signed [srpq_pkg::PRI_W-1:0] i_priority_req,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [srpq_pkg::PAY_W-1:0]             o_payload_out,
    output logic signed [srpq_pkg::PRI_W-1:0]      o_priority_out,
    output logic [1:0]                             o_status,
    output logic [srpq_pkg::CNT_W-1:0]             o_count,
    output logic                                   o_empty_res,
    output logic                                   o_full_res
);

    logic [srpq_pkg::CNT_W-1:0] r_cap, n_cap;
    logic [srpq_pkg::CNT_W-1:0] r_cap_eff, n_cap_eff;
    logic                       cap_wr;
    srpq_pkg::t_ram_req         ram_req;
    srpq_pkg::t_entry           ram_rdata;

    assign cap_wr = psel & penable & pwrite & (paddr[2] == srpq_pkg::REG_CAPACITY);

    always_comb begin
        n_cap     = r_cap;
        n_cap_eff = r_cap_eff;
        if (cap_wr) begin
            n_cap     = pwdata[srpq_pkg::CNT_W-1:0];
            n_cap_eff = srpq_pkg::cap_eff(pwdata[srpq_pkg::CNT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= srpq_pkg::CNT_W'(srpq_pkg::DEPTH);
            r_cap_eff <= srpq_pkg::CNT_W'(srpq_pkg::DEPTH);
        end else begin
            r_cap     <= n_cap;
            r_cap_eff <= n_cap_eff;
        end
    end

    assign prdata = (paddr[2] == srpq_pkg::REG_CAPACITY) ?
                    srpq_pkg::DATA_W'(r_cap) : '0;
    assign pready = 1'b1;

    srpq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cap          (r_cap_eff),
        .i_flush        (cap_wr),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_payload      (i_payload),
        .i_priority_req (i_priority_req),
        .o_ram_req      (ram_req),
        .i_ram_rdata    (ram_rdata),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_payload_out  (o_payload_out),
        .o_priority_out (o_priority_out),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_empty_res    (o_empty_res),
        .o_full_res     (o_full_res)
    );

    srpq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire
